[design/tpe_pkg.sv]
package tpe_pkg;

    localparam int MaxSpec   = 16;
    localparam int CntW      = $clog2(MaxSpec + 1);
    localparam int IdxW      = $clog2(MaxSpec);
    localparam logic [23:0] RepMax = 24'hFFFFFF;
    localparam logic [31:0] LenMax = 32'hFFFFFFFF;

    // padding count saturates once the product reaches (RepMax + 1) * 10000
    localparam logic [48:0] SatLimit = 49'd167772160000;
    // ceil(2^44 / 625): product >> 4 divided by 625, exact below 2^34
    localparam logic [34:0] DivRecip = 35'd28147497672;

    localparam logic [1:0] CFG_LINE_BAUD = 2'd0;
    localparam logic [1:0] CFG_PAD_BYTE  = 2'd1;
    localparam logic [1:0] CFG_MIN_BAUD  = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DOLLAR, PH_LT, PH_INT, PH_DOT, PH_SKIP
    } phase_t;

    typedef enum logic [3:0] {
        ST_WAIT, ST_PARSE, ST_FLUSH, ST_REFEED, ST_MUL2, ST_DIV, ST_DIV2, ST_PAD,
        ST_LAST
    } state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
        logic [9:0] affected_lines;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [23:0] repeat_count;
        logic        is_last;
        logic [31:0] total_length;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic clear_parse;
        logic hold;
        logic upd_parse;
        logic idle_dollar;
        logic mul1;
        logic mul2;
        logic div;
        logic div2;
        logic emit_pend;
        logic emit_lit;
        logic emit_pad;
        logic emit_last;
        logic flush_step;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       eos;
        logic       is_dollar;
        logic       is_lt;
        logic       is_gt;
        logic       is_digit;
        logic       is_dot;
        logic       full;
        logic       flush_done;
        logic       pad_ok;
        phase_t     phase;
    } dp_sts_t;

endpackage

[design/terminal_padding_expander_unit.sv]
// A plain byte goes out as its own word; a closing '>' computes its pad count
// (value, times baud/8, two-step reciprocal divide by 10000) and sends a pad word
// only if line baud >= min baud and the count is nonzero. A flush sends the held
// bytes, one word per cycle while the output is not stalled, then the refed byte
// (none for a '$') or the closing word. No new byte is taken until one is handled.
// Reset: aresetn synchronous active low; config to reset values, parser idle.
module terminal_padding_expander_unit import tpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    out_busy;

    // controller: sequences parse, flush, padding arithmetic and output
    tpe_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .out_busy, .sts, .cmd
    );

    // datapath: parser state, held bytes, multiplier, divider, output word
    tpe_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_word, .cmd, .sts,
        .out_busy, .m_valid, .m_ready, .m_word
    );

endmodule

[design/tpe_ctrl.sv]
module tpe_ctrl import tpe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    out_busy,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   refeed_reg, refeed_next;  // after flush, handle byte as fresh

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_WAIT;
            refeed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            refeed_reg <= refeed_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        refeed_next = refeed_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_WAIT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PARSE;
                end
            end
            ST_PARSE: begin
                if (sts.eos) begin
                    refeed_next = 1'b0;
                    state_next  = ST_FLUSH;
                end else begin
                    case (sts.phase)
                        PH_DOLLAR: begin
                            if (sts.is_lt) begin
                                cmd.hold = 1'b1; cmd.upd_parse = 1'b1;
                                state_next = ST_WAIT;
                            end else begin
                                refeed_next = 1'b1; state_next = ST_FLUSH;
                            end
                        end
                        PH_LT: begin
                            if (sts.is_digit || sts.is_dot) begin
                                cmd.hold = 1'b1; cmd.upd_parse = 1'b1;
                                state_next = ST_WAIT;
                            end else begin
                                refeed_next = 1'b1; state_next = ST_FLUSH;
                            end
                        end
                        PH_INT, PH_DOT, PH_SKIP: begin
                            if (sts.is_gt) begin
                                cmd.mul1 = 1'b1; state_next = ST_MUL2;
                            end else if (sts.full) begin
                                refeed_next = 1'b1; state_next = ST_FLUSH;
                            end else begin
                                cmd.hold = 1'b1; cmd.upd_parse = 1'b1;
                                state_next = ST_WAIT;
                            end
                        end
                        default: state_next = ST_REFEED;
                    endcase
                end
            end
            ST_FLUSH: begin
                if (sts.flush_done) begin
                    cmd.clear_parse = 1'b1;
                    state_next = refeed_reg ? ST_REFEED : ST_LAST;
                end else if (!out_busy) begin
                    cmd.emit_pend  = 1'b1;
                    cmd.flush_step = 1'b1;
                end
            end
            ST_REFEED: begin
                if (sts.is_dollar) begin
                    cmd.idle_dollar = 1'b1;
                    state_next = ST_WAIT;
                end else if (!out_busy) begin
                    cmd.emit_lit = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_MUL2: begin
                cmd.mul2 = 1'b1; state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1; state_next = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div2 = 1'b1; state_next = ST_PAD;
            end
            ST_PAD: begin
                if (!sts.pad_ok) begin
                    cmd.clear_parse = 1'b1; state_next = ST_WAIT;
                end else if (!out_busy) begin
                    cmd.emit_pad = 1'b1; cmd.clear_parse = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_LAST: begin
                if (!out_busy) begin
                    cmd.emit_last = 1'b1; state_next = ST_WAIT;
                end
            end
            default: state_next = ST_WAIT;
        endcase
    end

    ap_ready_only_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_WAIT) else $error("ready outside wait");
    ap_accept_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_PARSE) else $error("no parse");
    ap_emit_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.emit_pend, cmd.emit_lit, cmd.emit_pad, cmd.emit_last}) <= 1)
        else $error("double emit");

endmodule

[design/tpe_dp.sv]
module tpe_dp import tpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data,
    input  in_word_t    s_word,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic        out_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word
);

    logic [21:0] line_baud_reg, min_baud_reg;
    logic [7:0]  pad_byte_reg;
    in_word_t    in_reg;
    phase_t      phase_reg;
    logic [CntW-1:0] count_reg, fptr_reg;
    logic [15:0] whole_reg;
    logic [3:0]  tenth_reg;
    logic        star_reg;
    logic [31:0] sent_reg;
    logic [48:0] prod_reg;   // value, then baud/8 * value
    logic        sat_reg;
    logic [51:0] pp_hi_reg, pp_lo_reg;
    logic [23:0] rep_reg;
    logic        out_v_reg;
    out_word_t   out_reg;
    logic [7:0]  pend_reg [MaxSpec];

    logic [7:0] b;
    logic       dig;
    logic [3:0] dval;
    logic [19:0] w10;
    logic [19:0] val20;
    logic [23:0] emit_rep;
    logic [7:0]  emit_byte;
    logic        emit;
    logic [32:0] sum;
    logic [67:0] qsum;

    assign b    = in_reg.in_byte;
    assign dig  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign dval = 4'(b - CH_ZERO);
    assign w10  = 20'(whole_reg) * 20'd10 + 20'(dval);
    assign val20 = 20'(whole_reg) * 20'd10 + 20'(tenth_reg);

    assign sts.eos        = in_reg.end_of_string;
    assign sts.is_dollar  = (b == CH_DOLLAR);
    assign sts.is_lt      = (b == CH_LT);
    assign sts.is_gt      = (b == CH_GT);
    assign sts.is_digit   = dig;
    assign sts.is_dot     = (b == CH_DOT);
    assign sts.full       = (count_reg >= CntW'(MaxSpec - 1));
    assign sts.flush_done = (fptr_reg >= count_reg);
    assign sts.pad_ok     = (line_baud_reg >= min_baud_reg) && (rep_reg != '0);
    assign sts.phase      = phase_reg;

    assign out_busy = out_v_reg && !m_ready;
    assign m_valid  = out_v_reg;
    assign m_word   = out_reg;

    // divide by 10000 in two steps: drop a factor of 16, then multiply the
    // 34-bit quotient by the reciprocal of 625 in two 17-bit halves
    assign qsum = 68'({pp_hi_reg, 17'd0} + 69'(pp_lo_reg));

    always_comb begin
        emit      = cmd.emit_pend || cmd.emit_lit || cmd.emit_pad;
        emit_byte = b;
        emit_rep  = 24'd1;
        if (cmd.emit_pend) emit_byte = pend_reg[fptr_reg[IdxW-1:0]];
        if (cmd.emit_pad) begin
            emit_byte = pad_byte_reg;
            emit_rep  = rep_reg;
        end
        sum = {1'b0, sent_reg} + 33'(emit_rep);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_baud_reg <= 22'd9600;
            pad_byte_reg  <= '0;
            min_baud_reg  <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            fptr_reg      <= '0;
            whole_reg     <= '0;
            tenth_reg     <= '0;
            star_reg      <= 1'b0;
            sent_reg      <= '0;
            out_v_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LINE_BAUD: line_baud_reg <= cfg_data;
                    CFG_PAD_BYTE:  pad_byte_reg  <= cfg_data[7:0];
                    CFG_MIN_BAUD:  min_baud_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (emit || cmd.emit_last) out_v_reg <= 1'b1;
            else if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (emit) begin
                out_reg   <= '{emit_byte, emit_rep, 1'b0, 32'd0};
                sent_reg  <= sum[32] ? LenMax : sum[31:0];
            end
            if (cmd.emit_last) begin
                out_reg   <= '{8'd0, 24'd0, 1'b1, sent_reg};
                sent_reg  <= '0;
            end
            if (cmd.flush_step) fptr_reg <= fptr_reg + 1'b1;
            if (cmd.clear_parse) begin
                count_reg <= '0; fptr_reg <= '0; phase_reg <= PH_IDLE;
                whole_reg <= '0; tenth_reg <= '0; star_reg <= 1'b0;
            end
            if (cmd.idle_dollar) begin
                count_reg <= CntW'(1);
                phase_reg <= PH_DOLLAR;
            end
            if (cmd.hold) count_reg <= count_reg + 1'b1;
            if (cmd.upd_parse) begin
                case (phase_reg)
                    PH_DOLLAR: phase_reg <= PH_LT;
                    PH_LT: begin
                        if (dig) begin
                            whole_reg <= 16'(dval); phase_reg <= PH_INT;
                        end else phase_reg <= PH_DOT;
                    end
                    PH_INT: begin
                        star_reg <= (b == CH_STAR);
                        if (dig) whole_reg <= (w10 > 20'd65535) ? 16'hFFFF : w10[15:0];
                        else if (b == CH_DOT) phase_reg <= PH_DOT;
                        else phase_reg <= PH_SKIP;
                    end
                    PH_DOT: begin
                        star_reg <= (b == CH_STAR);
                        if (dig) tenth_reg <= dval;
                        phase_reg <= PH_SKIP;
                    end
                    default: star_reg <= (b == CH_STAR);
                endcase
            end
            if (cmd.mul1)
                prod_reg <= 49'(30'(val20)
                          * (star_reg ? 30'(in_reg.affected_lines) : 30'd1));
            if (cmd.mul2)
                prod_reg <= {19'd0, prod_reg[29:0]} * {30'd0, line_baud_reg[21:3]};
            if (cmd.div) begin
                sat_reg   <= (prod_reg >= SatLimit);
                pp_hi_reg <= {35'd0, prod_reg[37:21]} * {17'd0, DivRecip};
                pp_lo_reg <= {35'd0, prod_reg[20:4]} * {17'd0, DivRecip};
            end
            if (cmd.div2)
                rep_reg <= sat_reg ? RepMax : qsum[67:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) in_reg <= s_word;
        if (cmd.hold) pend_reg[count_reg[IdxW-1:0]] <= b;
        if (cmd.idle_dollar) pend_reg[0] <= b;
    end

    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxSpec)) else $error("count overflow");
    ap_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_last |=> sent_reg == '0) else $error("length not cleared");
    ap_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> count_reg == '0) else $error("idle holds bytes");

endmodule
